FILE: design/qpd_pkg.sv
package qpd_pkg;

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam int unsigned MaxRes = 3;

  // escape phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_EQ    = 2'd1;
  localparam logic [1:0] PH_EQCR  = 2'd2;
  localparam logic [1:0] PH_EQHEX = 2'd3;

  // results caused by one input byte, in emission order
  typedef struct packed {
    logic [1:0]                cnt;   // 0..3
    logic [MaxRes-1:0][7:0]    bytes;
    logic [MaxRes-1:0]         bv;
    logic                      last;
  } qpd_bundle_t;

  typedef struct packed {
    logic [1:0]  phase_nxt;
    logic [7:0]  held_nxt;
    qpd_bundle_t bundle;
  } qpd_dec_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: design/qpd_decode.sv
module qpd_decode
  import qpd_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic [1:0] phase_i,
  input  logic [7:0] held_i,
  output qpd_dec_t   dec_o
);

  logic [4:0] hv_in;
  logic [4:0] hv_held;

  assign hv_in   = hex_val(byte_i);
  assign hv_held = hex_val(held_i);

  always_comb begin
    logic [1:0]             n;
    logic [1:0]             ph;
    logic [7:0]             hd;
    logic [MaxRes-1:0][7:0] rb;
    logic [MaxRes-1:0]      rv;
    logic                   pb_en;
    logic [7:0]             pb;

    n     = 2'd0;
    ph    = phase_i;
    hd    = held_i;
    rb    = '0;
    rv    = '0;
    pb_en = 1'b0;
    pb    = byte_i;

    case (phase_i)
      PH_IDLE: begin
        pb_en = 1'b1;
      end
      PH_EQ: begin
        if (byte_i == CH_CR) begin
          ph = PH_EQCR;
        end else if (byte_i == CH_LF) begin
          ph = PH_IDLE;
        end else if (hv_in[4]) begin
          hd = byte_i;
          ph = PH_EQHEX;
        end else begin
          ph = PH_IDLE;
          rb[0] = CH_EQ; rv[0] = 1'b1; n = 2'd1;
          pb_en = 1'b1;
        end
      end
      PH_EQCR: begin
        ph    = PH_IDLE;
        pb_en = (byte_i != CH_LF);
      end
      default: begin
        ph = PH_IDLE;
        if (hv_in[4]) begin
          // a non-hex held char cannot occur; it would decode as high nibble 0
          rb[0] = {(hv_held[4] ? hv_held[3:0] : 4'd0), hv_in[3:0]};
          rv[0] = 1'b1;
          n     = 2'd1;
        end else begin
          rb[0] = CH_EQ;  rv[0] = 1'b1;
          rb[1] = held_i; rv[1] = 1'b1;
          n     = 2'd2;
          pb_en = 1'b1;
        end
      end
    endcase

    // byte reprocessed as fresh input
    if (pb_en) begin
      if (pb == CH_EQ) begin
        ph = PH_EQ;
      end else if (n != 2'd3) begin
        rb[n] = pb; rv[n] = 1'b1;
        n = n + 2'd1;
      end
    end

    if (last_i) begin
      if (ph == PH_EQ && n != 2'd3) begin
        rb[n] = CH_EQ; rv[n] = 1'b1;
        n = n + 2'd1;
      end else if (ph == PH_EQHEX && n == 2'd0) begin
        rb[0] = CH_EQ; rv[0] = 1'b1;
        rb[1] = hd;    rv[1] = 1'b1;
        n = 2'd2;
      end
      ph = PH_IDLE;
      hd = 8'd0;
      if (n == 2'd0) begin
        // bare end marker
        rb[0] = 8'd0; rv[0] = 1'b0;
        n = 2'd1;
      end
    end

    dec_o.phase_nxt    = ph;
    dec_o.held_nxt     = hd;
    dec_o.bundle.cnt   = n;
    dec_o.bundle.bytes = rb;
    dec_o.bundle.bv    = rv;
    dec_o.bundle.last  = last_i;
  end

endmodule

FILE: design/quoted_printable_decoder_top.sv
// Path: an accepted byte waits in the input register, is decoded, and its
// results are registered in the result bundle, which drives out_valid.
// Throughput: one input byte per cycle when each byte makes at most one
// result and out_ready is high; several results from one item hold the port.
// A one-entry input register lets a new byte in while a result waits.
// Reset (rst_n low, synchronous) empties both stages and returns to idle.
module quoted_printable_decoder_top
  import qpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  logic        item_valid_r;
  logic [7:0]  item_byte_r;
  logic        item_last_r;

  logic [1:0]  phase_r;
  logic [7:0]  held_r;

  logic        bun_valid_r;
  qpd_bundle_t bun_r;
  logic [1:0]  idx_r;

  qpd_dec_t    dec;
  logic        out_xfer;
  logic        drain_done;
  logic        load;

  qpd_decode u_dec (
    .byte_i  (item_byte_r),
    .last_i  (item_last_r),
    .phase_i (phase_r),
    .held_i  (held_r),
    .dec_o   (dec)
  );

  assign out_xfer   = bun_valid_r && out_ready;
  assign drain_done = out_xfer && (idx_r == bun_r.cnt - 2'd1);
  assign load       = item_valid_r && (!bun_valid_r || drain_done);
  assign in_ready   = !item_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_byte_r <= in_byte;
      item_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      held_r      <= 8'd0;
      bun_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        phase_r     <= dec.phase_nxt;
        held_r      <= dec.held_nxt;
        // a byte that only moves the escape state makes no result
        bun_valid_r <= (dec.bundle.cnt != 2'd0);
        idx_r       <= 2'd0;
      end else if (drain_done) begin
        bun_valid_r <= 1'b0;
        idx_r       <= 2'd0;
      end else if (out_xfer) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bun_r <= dec.bundle;
    end
  end

  assign out_valid      = bun_valid_r;
  assign out_byte       = bun_r.bytes[idx_r];
  assign out_byte_valid = bun_r.bv[idx_r];
  assign out_last       = bun_r.last && (idx_r == bun_r.cnt - 2'd1);

endmodule

FILE: design/qpd_checker.sv
module qpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_last
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_byte_valid) && $stable(out_last))
    else $error("result changed while stalled");

  // an empty result only ever marks the end of a body
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last)
    else $error("bare marker without last");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0)
    else $error("bare marker carries a byte");

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind quoted_printable_decoder_top qpd_checker u_qpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_last       (out_last)
);
